### hw/rtl/stkc_pkg.sv
// stkc_pkg: shared constants, instruction field codes and port structs
// for the stack cpu core. Used by every module in hw/rtl.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package stkc_pkg;

  // word and stack geometry
  localparam int WORD_W      = 16;
  localparam int STACK_DEPTH = 32;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int STEP_W      = 32;
  localparam int RAM_WORDS_DEFAULT = 16384;

  // instruction classes, bits 14:13 when bit 15 is clear
  localparam logic [1:0] KIND_JUMP = 2'd0;
  localparam logic [1:0] KIND_COND = 2'd1;
  localparam logic [1:0] KIND_CALL = 2'd2;
  localparam logic [1:0] KIND_ALU  = 2'd3;

  // alu operations, bits 11:8
  localparam logic [3:0] ALU_T    = 4'h0;
  localparam logic [3:0] ALU_N    = 4'h1;
  localparam logic [3:0] ALU_ADD  = 4'h2;
  localparam logic [3:0] ALU_AND  = 4'h3;
  localparam logic [3:0] ALU_OR   = 4'h4;
  localparam logic [3:0] ALU_XOR  = 4'h5;
  localparam logic [3:0] ALU_INV  = 4'h6;
  localparam logic [3:0] ALU_EQ   = 4'h7;
  localparam logic [3:0] ALU_SLT  = 4'h8;
  localparam logic [3:0] ALU_SHR  = 4'h9;
  localparam logic [3:0] ALU_DEC  = 4'hA;
  localparam logic [3:0] ALU_R    = 4'hB;
  localparam logic [3:0] ALU_LOAD = 4'hC;
  localparam logic [3:0] ALU_SHL  = 4'hD;
  localparam logic [3:0] ALU_DEPTH = 4'hE;
  localparam logic [3:0] ALU_ULT  = 4'hF;

  // i/o map
  localparam logic [WORD_W-1:0] IO_LOW     = 16'h6000;
  localparam logic [WORD_W-1:0] IO_HIGH    = 16'h6002;
  localparam logic [WORD_W-1:0] IO_DEFAULT = 16'h0946;
  localparam logic [WORD_W-1:0] LIT_MASK   = 16'h7fff;

  // one write into a stack
  typedef struct packed {
    logic             en;
    logic [PTR_W-1:0] addr;
    logic [WORD_W-1:0] data;
  } stack_wr_t;

  // one write into data memory (address already known to be in ram space)
  typedef struct packed {
    logic              en;
    logic [WORD_W-1:0] addr;
    logic [WORD_W-1:0] data;
  } mem_wr_t;

endpackage

`default_nettype wire

### hw/rtl/stkc_stack.sv
// stkc_stack: register file for one 32-entry stack, one write port and
// one combinational read port. Depends on stkc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stkc_stack
  import stkc_pkg::*;
(
  input  wire logic              clk,
  input  wire stack_wr_t         wr,
  input  wire logic [PTR_W-1:0]  rd_addr,
  output logic      [WORD_W-1:0] rd_data
);

  logic [WORD_W-1:0] entries [STACK_DEPTH];

  // entry write
  always_ff @(posedge clk) begin
    if (wr.en) begin
      entries[wr.addr] <= wr.data;
    end
  end

  // top-of-stack read
  assign rd_data = entries[rd_addr];

endmodule

`default_nettype wire

### hw/rtl/stkc_dmem.sv
// stkc_dmem: single-write data ram with a registered read port and
// write-first forwarding. Depends on stkc_pkg. RAM_WORDS is a power of two.
`timescale 1ns / 1ps
`default_nettype none

module stkc_dmem
  import stkc_pkg::*;
#(
  parameter int RAM_WORDS = RAM_WORDS_DEFAULT
) (
  input  wire logic              clk,
  input  wire mem_wr_t           wr,
  input  wire logic [WORD_W-1:0] rd_addr,
  output logic      [WORD_W-1:0] rd_data
);

  localparam int AW = $clog2(RAM_WORDS);

  logic [WORD_W-1:0] mem [RAM_WORDS];
  logic [AW-1:0]     widx;
  logic [AW-1:0]     ridx;

  // addresses wrap modulo the ram size
  assign widx = wr.addr[AW-1:0];
  assign ridx = rd_addr[AW-1:0];

  // write, and read with same-cycle write forwarded
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[widx] <= wr.data;
    end
    if (wr.en && (widx == ridx)) begin
      rd_data <= wr.data;
    end else begin
      rd_data <= mem[ridx];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/stkc_alu.sv
// stkc_alu: the sixteen alu operations, including the memory and i/o
// load path. Purely combinational. Depends on stkc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stkc_alu
  import stkc_pkg::*;
(
  input  wire logic [3:0]        op,
  input  wire logic [WORD_W-1:0] t,
  input  wire logic [WORD_W-1:0] n,
  input  wire logic [WORD_W-1:0] r,
  input  wire logic [PTR_W-1:0]  dp,
  input  wire logic [PTR_W-1:0]  rp,
  input  wire logic [WORD_W-1:0] ram_data,
  input  wire logic [STEP_W-1:0] step_count,
  output logic      [WORD_W-1:0] result
);

  logic [3:0]        sh;
  logic [WORD_W-1:0] load_val;

  assign sh = t[3:0];

  // ram below 0x4000, i/o above
  always_comb begin
    if (t[15:14] == 2'b00) begin
      load_val = ram_data;
    end else if (t == IO_LOW) begin
      load_val = step_count[15:0];
    end else if (t == IO_HIGH) begin
      load_val = step_count[31:16];
    end else begin
      load_val = IO_DEFAULT;
    end
  end

  // operation select
  always_comb begin
    case (op)
      ALU_T:     result = t;
      ALU_N:     result = n;
      ALU_ADD:   result = t + n;
      ALU_AND:   result = t & n;
      ALU_OR:    result = t | n;
      ALU_XOR:   result = t ^ n;
      ALU_INV:   result = ~t;
      ALU_EQ:    result = (n == t) ? 16'hffff : 16'h0000;
      ALU_SLT:   result = ($signed(n) < $signed(t)) ? 16'hffff : 16'h0000;
      ALU_SHR:   result = n >> sh;
      ALU_DEC:   result = t - 16'd1;
      ALU_R:     result = r;
      ALU_LOAD:  result = load_val;
      ALU_SHL:   result = n << sh;
      ALU_DEPTH: result = {4'b0000, rp, 2'b00, dp};
      ALU_ULT:   result = (n < t) ? 16'hffff : 16'h0000;
      default:   result = t;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/stack_cpu_core_top.sv
// stack_cpu_core_top: one instruction per transfer, held in ir; its result
// is registered in the state registers. One instruction per cycle while
// out_stall is low, set by the execute loop through top, pointers, stacks.
// Synchronous reset clears pc, top, both stack pointers, the step counter and
// the handshake state; stacks and data ram hold no reset value.
// Depends on stkc_pkg, stkc_alu, stkc_stack, stkc_dmem.
`timescale 1ns / 1ps
`default_nettype none

module stack_cpu_core_top
  import stkc_pkg::*;
#(
  parameter int RAM_WORDS = RAM_WORDS_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [WORD_W-1:0] instruction,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [WORD_W-1:0] next_pc,
  output logic      [WORD_W-1:0] top_value,
  output logic      [PTR_W-1:0]  data_depth,
  output logic      [PTR_W-1:0]  return_depth
);

  // architectural state
  logic [WORD_W-1:0] pc, pc_next;
  logic [WORD_W-1:0] top, top_next;
  logic [PTR_W-1:0]  dp, dp_next;
  logic [PTR_W-1:0]  rp, rp_next;
  logic [STEP_W-1:0] step_count;

  // input register
  logic [WORD_W-1:0] ir;
  logic              ir_valid;

  logic fire;
  logic take;

  logic [WORD_W-1:0] n_val, r_val, ram_data, alu_result;
  logic [WORD_W-1:0] pc_inc;
  logic [PTR_W-1:0]  dp_m1, rp_m1, dp_adj, rp_adj;
  logic [1:0]        kind;
  stack_wr_t         ds_wr, rs_wr;
  mem_wr_t           mem_wr;

  // handshake: execute when the result slot is free or being drained
  assign fire     = ir_valid && (!out_valid || !out_stall);
  assign in_stall = ir_valid && !fire;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        ir_valid <= 1'b1;
      end else if (fire) begin
        ir_valid <= 1'b0;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ir <= instruction;
    end
  end

  // decode helpers
  assign kind   = ir[14:13];
  assign pc_inc = pc + 16'd1;
  assign dp_m1  = dp - PTR_W'(1);
  assign rp_m1  = rp - PTR_W'(1);
  assign dp_adj = dp + {{(PTR_W-2){ir[1]}}, ir[1:0]};
  assign rp_adj = rp + {{(PTR_W-2){ir[3]}}, ir[3:2]};

  // stacks and memory
  stkc_stack u_dstack (
    .clk     (clk),
    .wr      (ds_wr),
    .rd_addr (dp_m1),
    .rd_data (n_val)
  );

  stkc_stack u_rstack (
    .clk     (clk),
    .wr      (rs_wr),
    .rd_addr (rp_m1),
    .rd_data (r_val)
  );

  // read port tracks the top that the next instruction will see
  stkc_dmem #(
    .RAM_WORDS (RAM_WORDS)
  ) u_dmem (
    .clk     (clk),
    .wr      (mem_wr),
    .rd_addr (top_next),
    .rd_data (ram_data)
  );

  stkc_alu u_alu (
    .op         (ir[11:8]),
    .t          (top),
    .n          (n_val),
    .r          (r_val),
    .dp         (dp),
    .rp         (rp),
    .ram_data   (ram_data),
    .step_count (step_count),
    .result     (alu_result)
  );

  // execute
  always_comb begin
    pc_next  = pc;
    top_next = top;
    dp_next  = dp;
    rp_next  = rp;
    ds_wr    = '0;
    rs_wr    = '0;
    mem_wr   = '0;
    if (fire) begin
      pc_next = pc_inc;
      if (ir[15]) begin
        // literal push
        ds_wr.en   = 1'b1;
        ds_wr.addr = dp;
        ds_wr.data = top;
        dp_next    = dp + PTR_W'(1);
        top_next   = ir & LIT_MASK;
      end else begin
        case (kind)
          KIND_ALU: begin
            top_next    = alu_result;
            dp_next     = dp_adj;
            rp_next     = rp_adj;
            mem_wr.en   = ir[5] && (top[15:14] == 2'b00);
            mem_wr.addr = top;
            mem_wr.data = n_val;
            rs_wr.en    = ir[6];
            rs_wr.addr  = rp_adj - PTR_W'(1);
            rs_wr.data  = top;
            ds_wr.en    = ir[7];
            ds_wr.addr  = dp_adj - PTR_W'(1);
            ds_wr.data  = top;
            if (ir[12]) begin
              pc_next = r_val;
            end
          end
          KIND_CALL: begin
            rs_wr.en   = 1'b1;
            rs_wr.addr = rp;
            rs_wr.data = pc_inc;
            rp_next    = rp + PTR_W'(1);
            pc_next    = {3'b000, ir[12:0]};
          end
          KIND_COND: begin
            if (top == '0) begin
              pc_next = {3'b000, ir[12:0]};
            end
          end
          KIND_JUMP: begin
            pc_next = {3'b000, ir[12:0]};
          end
          default: begin
            pc_next = pc_inc;
          end
        endcase
      end
    end
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      pc         <= '0;
      top        <= '0;
      dp         <= '0;
      rp         <= '0;
      step_count <= '0;
    end else begin
      pc  <= pc_next;
      top <= top_next;
      dp  <= dp_next;
      rp  <= rp_next;
      if (fire) begin
        step_count <= step_count + 32'd1;
      end
    end
  end

  // state registers double as the result register
  assign next_pc      = pc;
  assign top_value    = top;
  assign data_depth   = dp;
  assign return_depth = rp;

endmodule

`default_nettype wire

### tb/stack_cpu_core_checker.sv
// stack_cpu_core_checker: predicts every step of the stack cpu core from the
// accepted instruction transfers and compares each result transfer in order.
// Depends on stkc_pkg.
`timescale 1ns / 1ps

module stack_cpu_core_checker
  import stkc_pkg::*;
#(
  parameter int RAM_WORDS = RAM_WORDS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [WORD_W-1:0]    instruction,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [WORD_W-1:0]    next_pc,
  input  logic [WORD_W-1:0]    top_value,
  input  logic [PTR_W-1:0]     data_depth,
  input  logic [PTR_W-1:0]     return_depth,
  // predicted machine state, used by the stimulus to stay on written entries
  output logic [WORD_W-1:0]    cur_top,
  output logic [PTR_W-1:0]     cur_dp,
  output logic [PTR_W-1:0]     cur_rp,
  output logic [STACK_DEPTH-1:0] ds_known,
  output logic [STACK_DEPTH-1:0] rs_known,
  output logic [RAM_WORDS-1:0] ram_known,
  output int                   pending,
  output int                   fail_count
);

  typedef struct packed {
    logic [WORD_W-1:0] pc;
    logic [WORD_W-1:0] top;
    logic [PTR_W-1:0]  dp;
    logic [PTR_W-1:0]  rp;
  } step_out_t;

  step_out_t         expected_steps[$];
  logic [WORD_W-1:0] cur_pc;
  logic [STEP_W-1:0] steps_done;
  logic [WORD_W-1:0] dstack[STACK_DEPTH];
  logic [WORD_W-1:0] rstack[STACK_DEPTH];
  logic [WORD_W-1:0] ram[RAM_WORDS];

  // 2-bit signed pointer adjust, wraps with the pointer width
  function automatic logic [PTR_W-1:0] shift_ptr(logic [PTR_W-1:0] p, logic [1:0] d);
    return p + {{(PTR_W-2){d[1]}}, d};
  endfunction

  // data ram below 0x4000, step counter halves and a fixed word elsewhere
  function automatic logic [WORD_W-1:0] read_word(logic [WORD_W-1:0] a);
    if (a[15:14] != 2'b00) begin
      if (a == IO_LOW) return steps_done[15:0];
      if (a == IO_HIGH) return steps_done[31:16];
      return IO_DEFAULT;
    end
    return ram[a % RAM_WORDS];
  endfunction

  // one instruction: update the machine and queue the step it reports
  task automatic execute_word(input logic [WORD_W-1:0] ir);
    logic [WORD_W-1:0] next;
    logic [WORD_W-1:0] t;
    logic [WORD_W-1:0] n;
    logic [WORD_W-1:0] r;
    logic [WORD_W-1:0] res;
    logic [PTR_W-1:0]  below;
    logic [3:0]        sh;
    next = cur_pc + 1'b1;
    if (ir[15]) begin
      // literal push
      dstack[cur_dp] = cur_top;
      ds_known[cur_dp] = 1'b1;
      cur_dp = cur_dp + 1'b1;
      cur_top = ir & LIT_MASK;
    end else begin
      case (ir[14:13])
        KIND_ALU: begin
          t = cur_top;
          below = cur_dp - 1'b1;
          n = dstack[below];
          below = cur_rp - 1'b1;
          r = rstack[below];
          sh = t[3:0];
          case (ir[11:8])
            ALU_T:     res = t;
            ALU_N:     res = n;
            ALU_ADD:   res = t + n;
            ALU_AND:   res = t & n;
            ALU_OR:    res = t | n;
            ALU_XOR:   res = t ^ n;
            ALU_INV:   res = ~t;
            ALU_EQ:    res = {WORD_W{n == t}};
            ALU_SLT:   res = {WORD_W{$signed(n) < $signed(t)}};
            ALU_SHR:   res = n >> sh;
            ALU_DEC:   res = t - 1'b1;
            ALU_R:     res = r;
            ALU_LOAD:  res = read_word(t);
            ALU_SHL:   res = n << sh;
            ALU_DEPTH: res = {4'b0000, cur_rp, 2'b00, cur_dp};
            ALU_ULT:   res = {WORD_W{n < t}};
            default:   res = t;
          endcase
          // store of N to [T], i/o writes dropped
          if (ir[5] && t[15:14] == 2'b00) begin
            ram[t % RAM_WORDS] = n;
            ram_known[t % RAM_WORDS] = 1'b1;
          end
          cur_rp = shift_ptr(cur_rp, ir[3:2]);
          cur_dp = shift_ptr(cur_dp, ir[1:0]);
          // T->R and T->N land just below the adjusted pointers
          if (ir[6]) begin
            below = cur_rp - 1'b1;
            rstack[below] = t;
            rs_known[below] = 1'b1;
          end
          if (ir[7]) begin
            below = cur_dp - 1'b1;
            dstack[below] = t;
            ds_known[below] = 1'b1;
          end
          if (ir[12]) next = r;
          cur_top = res;
        end
        KIND_CALL: begin
          rstack[cur_rp] = next;
          rs_known[cur_rp] = 1'b1;
          cur_rp = cur_rp + 1'b1;
          next = {3'b000, ir[12:0]};
        end
        KIND_COND: begin
          if (cur_top == '0) next = {3'b000, ir[12:0]};
        end
        default: begin
          next = {3'b000, ir[12:0]};
        end
      endcase
    end
    cur_pc = next;
    steps_done = steps_done + 1'b1;
    expected_steps.push_back('{pc: cur_pc, top: cur_top, dp: cur_dp, rp: cur_rp});
  endtask

  task automatic compare_field(input string field, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", field, want, got);
      fail_count++;
    end
  endtask

  // result transfers are checked before the same-edge instruction is predicted
  always @(posedge clk) begin
    step_out_t want;
    if (rst) begin
      cur_pc = '0;
      cur_top = '0;
      cur_dp = '0;
      cur_rp = '0;
      steps_done = '0;
      ds_known = '0;
      rs_known = '0;
      ram_known = '0;
      expected_steps.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_steps.size() == 0) begin
          $error("unexpected result transfer: next_pc %h top_value %h", next_pc, top_value);
          fail_count++;
        end else begin
          want = expected_steps.pop_front();
          compare_field("next_pc", want.pc, next_pc);
          compare_field("top_value", want.top, top_value);
          compare_field("data_depth", WORD_W'(want.dp), WORD_W'(data_depth));
          compare_field("return_depth", WORD_W'(want.rp), WORD_W'(return_depth));
        end
      end
      if (in_valid && !in_stall) execute_word(instruction);
    end
    pending = expected_steps.size();
  end

endmodule

### tb/stack_cpu_core_top_tb.sv
// stack_cpu_core_top_tb: drives instruction transfers into the stack cpu core,
// stalls the result side at random and reports the verdict.
// Depends on stkc_pkg, stack_cpu_core_top and stack_cpu_core_checker.
`timescale 1ns / 1ps

module stack_cpu_core_top_tb;
  import stkc_pkg::*;

  localparam int RAM_SIZE    = RAM_WORDS_DEFAULT;
  localparam int RANDOM_ITEMS = 400;
  localparam int HOLD_AT     = 200;
  localparam int LONG_HOLD   = 120;
  localparam int CYCLE_LIMIT = 100000;

  // instruction field codes
  localparam logic [WORD_W-1:0] LIT_BIT   = 16'h8000;
  localparam logic [WORD_W-1:0] RET_BIT   = 16'h1000;
  localparam logic [WORD_W-1:0] T2N_BIT   = 16'h0080;
  localparam logic [WORD_W-1:0] T2R_BIT   = 16'h0040;
  localparam logic [WORD_W-1:0] STORE_BIT = 16'h0020;
  localparam logic [WORD_W-1:0] NO_FLAGS  = 16'h0000;
  localparam logic [1:0] ADJ_NONE = 2'b00;
  localparam logic [1:0] ADJ_UP   = 2'b01;
  localparam logic [1:0] ADJ_DOWN = 2'b11;

  localparam logic [3:0] OP_ORDER[16] = '{ALU_T, ALU_N, ALU_ADD, ALU_AND, ALU_OR,
                                           ALU_XOR, ALU_INV, ALU_LOAD, ALU_EQ, ALU_SLT,
                                           ALU_SHR, ALU_DEC, ALU_R, ALU_SHL, ALU_DEPTH,
                                           ALU_ULT};

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  logic [WORD_W-1:0]      instruction;
  logic                   out_valid;
  logic                   out_stall;
  logic [WORD_W-1:0]      next_pc;
  logic [WORD_W-1:0]      top_value;
  logic [PTR_W-1:0]       data_depth;
  logic [PTR_W-1:0]       return_depth;

  logic [WORD_W-1:0]      model_top;
  logic [PTR_W-1:0]       model_dp;
  logic [PTR_W-1:0]       model_rp;
  logic [STACK_DEPTH-1:0] ds_known;
  logic [STACK_DEPTH-1:0] rs_known;
  logic [RAM_SIZE-1:0]    ram_known;
  int                     pending;
  int                     fail_count;

  int                     sent_count;
  int                     cycle_count;
  logic                   sender_burst;
  logic                   hold_req;

  stack_cpu_core_top #(
    .RAM_WORDS(RAM_SIZE)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .instruction(instruction),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .next_pc(next_pc),
    .top_value(top_value),
    .data_depth(data_depth),
    .return_depth(return_depth)
  );

  stack_cpu_core_checker #(
    .RAM_WORDS(RAM_SIZE)
  ) chk (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .instruction(instruction),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .next_pc(next_pc),
    .top_value(top_value),
    .data_depth(data_depth),
    .return_depth(return_depth),
    .cur_top(model_top),
    .cur_dp(model_dp),
    .cur_rp(model_rp),
    .ds_known(ds_known),
    .rs_known(rs_known),
    .ram_known(ram_known),
    .pending(pending),
    .fail_count(fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [WORD_W-1:0] lit_word(logic [WORD_W-1:0] v);
    return LIT_BIT | (v & LIT_MASK);
  endfunction

  function automatic logic [WORD_W-1:0] branch_word(logic [1:0] kind, logic [12:0] target);
    return {1'b0, kind, target};
  endfunction

  function automatic logic [WORD_W-1:0] alu_word(logic [3:0] op, logic [WORD_W-1:0] flags,
                                                 logic [1:0] radj, logic [1:0] dadj);
    return {1'b0, KIND_ALU, 13'h0000} | {4'h0, op, 8'h00} | flags | {12'h000, radj, dadj};
  endfunction

  // keep alu words off stack entries and ram words that were never written
  function automatic logic [WORD_W-1:0] make_legal(logic [WORD_W-1:0] w);
    logic [PTR_W-1:0] below_d;
    logic [PTR_W-1:0] below_r;
    logic             n_ok;
    logic             r_ok;
    logic             m_ok;
    logic [3:0]       op;
    if (w[15] || w[14:13] != KIND_ALU) return w;
    below_d = model_dp - 1'b1;
    below_r = model_rp - 1'b1;
    n_ok = ds_known[below_d];
    r_ok = rs_known[below_r];
    m_ok = (model_top[15:14] != 2'b00) || ram_known[model_top % RAM_SIZE];
    op = w[11:8];
    if (!n_ok) w = w & ~STORE_BIT;
    if (!r_ok) w = w & ~RET_BIT;
    if ((!n_ok && op inside {ALU_N, ALU_ADD, ALU_AND, ALU_OR, ALU_XOR, ALU_EQ, ALU_SLT,
                             ALU_SHR, ALU_SHL, ALU_ULT}) ||
        (!r_ok && op == ALU_R) || (!m_ok && op == ALU_LOAD))
      w[11:8] = ALU_INV;
    return w;
  endfunction

  // ram words the store and load sequences share, at both ends of the ram
  function automatic logic [WORD_W-1:0] window_addr();
    if ($urandom_range(0, 1) == 0) return WORD_W'($urandom_range(0, 7));
    return WORD_W'(RAM_SIZE - 1 - $urandom_range(0, 7));
  endfunction

  // one instruction transfer, entered and left at a falling edge
  task automatic send_word(input logic [WORD_W-1:0] raw);
    int gap;
    gap = (hold_req || sender_burst) ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    instruction <= make_legal(raw);
    do @(posedge clk); while (!(in_valid && !in_stall));
    @(negedge clk);
    sent_count++;
    if (sent_count % 40 == 0) sender_burst = ($urandom_range(0, 3) == 0);
    if (sent_count == HOLD_AT) hold_req = 1'b1;
  endtask

  // result side: random stalls per transfer, one long hold-off on request
  initial begin
    int stall_len;
    int taken;
    logic burst;
    out_stall = 1'b0;
    taken = 0;
    burst = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        stall_len = burst ? 0 : $urandom_range(0, 16);
        if (stall_len != 0) begin
          out_stall <= 1'b1;
          repeat (stall_len) @(negedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      @(negedge clk);
      taken++;
      if (taken % 40 == 0) burst = ($urandom_range(0, 3) == 0);
    end
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // stimulus and verdict
  initial begin
    int choice;
    int pick;
    logic [WORD_W-1:0] addr;
    rst = 1'b1;
    in_valid = 1'b0;
    instruction = '0;
    sent_count = 0;
    sender_burst = 1'b0;
    hold_req = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // directed: literal extremes, the conditional branch taken and not taken, jump and call
    send_word(lit_word(16'h7fff));
    send_word(lit_word(16'h0000));
    send_word(branch_word(KIND_COND, 13'h1fff));
    send_word(lit_word(16'h0001));
    send_word(branch_word(KIND_COND, 13'h0000));
    send_word(branch_word(KIND_JUMP, 13'h1fff));
    send_word(branch_word(KIND_CALL, 13'h0000));
    // every alu op, the load landing on the default i/o word
    for (int k = 0; k < 16; k++) send_word(alu_word(OP_ORDER[k], NO_FLAGS, ADJ_NONE, ADJ_NONE));
    // all alu flags at once, then a step counter read
    send_word(alu_word(ALU_T, RET_BIT | T2N_BIT | T2R_BIT | STORE_BIT, ADJ_DOWN, ADJ_UP));
    send_word(lit_word(IO_LOW));
    send_word(alu_word(ALU_LOAD, NO_FLAGS, ADJ_NONE, ADJ_NONE));

    // random: raw words mixed with store and load sequences
    sent_count = 0;
    while (sent_count < RANDOM_ITEMS) begin
      choice = $urandom_range(0, 99);
      if (choice < 35) begin
        send_word({1'b0, KIND_ALU, 13'($urandom)});
      end else if (choice < 55) begin
        send_word(lit_word(WORD_W'($urandom)));
      end else if (choice < 65) begin
        send_word(branch_word(2'($urandom_range(0, 2)), 13'($urandom)));
      end else if (choice < 80) begin
        // store: value, address, N->[T] with one pop
        send_word(lit_word(WORD_W'($urandom)));
        send_word(lit_word(window_addr()));
        send_word(alu_word(ALU_T, STORE_BIT, ADJ_NONE, ADJ_DOWN));
      end else begin
        pick = $urandom_range(0, 3);
        case (pick)
          0:       addr = IO_LOW;
          1:       addr = IO_HIGH;
          2:       addr = WORD_W'($urandom_range(16'h4000, 16'h7fff));
          default: addr = window_addr();
        endcase
        send_word(lit_word(addr));
        send_word(alu_word(ALU_LOAD, NO_FLAGS, ADJ_NONE, ADJ_NONE));
      end
    end
    in_valid <= 1'b0;

    // drain, then give a stray result time to show up
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
